// File: design/jsu_pkg.sv
// ---------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Escape phases, character codes, decoder state and the result burst type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // widths and limits
  localparam int unsigned CAP_W    = 13;
  localparam int unsigned LEN_W    = 12;
  localparam int unsigned MAX_DATA = 5;   // data bytes one input can produce

  localparam logic [CAP_W-1:0] CAP_RESET    = 13'd64;
  localparam logic [CAP_W-1:0] MAX_CAPACITY = 13'd4096;

  // escape sequencer phase
  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESCAPE = 3'd1,
    PH_HEX0   = 3'd2,
    PH_HEX1   = 3'd3,
    PH_HEX2   = 3'd4,
    PH_HEX3   = 3'd5
  } jsu_phase_t;

  // character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CODE_BS   = 8'h08;
  localparam logic [7:0] CODE_FF   = 8'h0C;
  localparam logic [7:0] CODE_LF   = 8'h0A;
  localparam logic [7:0] CODE_CR   = 8'h0D;
  localparam logic [7:0] CODE_TAB  = 8'h09;

  // decoder state carried between input bytes
  typedef struct packed {
    jsu_phase_t       phase;
    logic [11:0]      hex_acc;
    logic [23:0]      held;
    logic [LEN_W-1:0] written;
  } jsu_state_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [MAX_DATA-1:0][7:0] data;
    logic [2:0]               ndata;
    logic                     term;
    logic [LEN_W-1:0]         base;
  } jsu_burst_t;

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/jsu_in_if.sv
// ---------------------------------------------------------------------------
// jsu_in_if: raw string byte channel
// valid/ready handshake carrying one content byte and its end flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, in_byte, end_of_text, input ready);
  modport sink   (input valid, in_byte, end_of_text, output ready);
endinterface

`default_nettype wire

// File: design/jsu_out_if.sv
// ---------------------------------------------------------------------------
// jsu_out_if: decoded result channel
// valid/ready handshake carrying one decoded byte or the terminator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_terminator;
  logic [11:0] text_length;
  logic        run_last;

  modport source (output valid, out_byte, is_terminator, text_length, run_last,
                  input ready);
  modport sink   (input valid, out_byte, is_terminator, text_length, run_last,
                  output ready);
endinterface

`default_nettype wire

// File: design/jsu_decode.sv
// ---------------------------------------------------------------------------
// jsu_decode: single-pass escape decoder
// From the current state and one input byte, forms the next state and the
// burst of results (data bytes after the capacity limit, plus terminator).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
  input  var jsu_pkg::jsu_state_t          st,
  input  wire logic [jsu_pkg::CAP_W-1:0]   capacity,
  input  wire logic [7:0]                  in_byte,
  input  wire logic                        end_of_text,
  output jsu_pkg::jsu_state_t              st_next,
  output jsu_pkg::jsu_burst_t              burst,
  output logic                             has_result
);

  logic [jsu_pkg::MAX_DATA-1:0][7:0] cand;
  logic [2:0]                        ncand;
  logic                              plain_en;
  logic [4:0]                        hexd;
  logic [1:0]                        k;
  logic [2:0]                        k_wide;
  logic [15:0]                       cp;
  logic [jsu_pkg::CAP_W-1:0]         cap_eff;
  logic [jsu_pkg::CAP_W-1:0]         used;
  logic [jsu_pkg::CAP_W-1:0]         room;
  logic [2:0]                        nemit;
  jsu_pkg::jsu_state_t               st_dec;

  assign hexd   = jsu_pkg::hex_digit(in_byte);
  assign k_wide = st.phase - 3'd2;
  assign k      = k_wide[1:0];
  assign cp     = {st.hex_acc, hexd[3:0]};

  // escape sequencing and candidate bytes
  always_comb begin
    cand     = '0;
    ncand    = 3'd0;
    plain_en = 1'b0;
    st_dec   = st;
    case (st.phase)
      jsu_pkg::PH_ESCAPE: begin
        st_dec.phase = jsu_pkg::PH_NORMAL;
        ncand        = 3'd1;
        case (in_byte)
          jsu_pkg::CH_B: cand[0] = jsu_pkg::CODE_BS;
          jsu_pkg::CH_F: cand[0] = jsu_pkg::CODE_FF;
          jsu_pkg::CH_N: cand[0] = jsu_pkg::CODE_LF;
          jsu_pkg::CH_R: cand[0] = jsu_pkg::CODE_CR;
          jsu_pkg::CH_T: cand[0] = jsu_pkg::CODE_TAB;
          jsu_pkg::CH_U: begin
            if (end_of_text) begin
              cand[0] = jsu_pkg::CH_U;
            end else begin
              ncand          = 3'd0;
              st_dec.phase   = jsu_pkg::PH_HEX0;
              st_dec.hex_acc = '0;
              st_dec.held    = '0;
            end
          end
          default: cand[0] = in_byte;
        endcase
      end
      jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
        if (hexd[4] && k == 2'd3) begin
          // fourth digit: code point to UTF-8, surrogates dropped
          st_dec.phase   = jsu_pkg::PH_NORMAL;
          st_dec.hex_acc = '0;
          st_dec.held    = '0;
          if (cp[15:11] == 5'b11011) begin
            ncand = 3'd0;
          end else if (cp < 16'h0080) begin
            cand[0] = cp[7:0];
            ncand   = 3'd1;
          end else if (cp < 16'h0800) begin
            cand[0] = 8'hC0 | {3'd0, cp[10:6]};
            cand[1] = 8'h80 | {2'd0, cp[5:0]};
            ncand   = 3'd2;
          end else begin
            cand[0] = 8'hE0 | {4'd0, cp[15:12]};
            cand[1] = 8'h80 | {2'd0, cp[11:6]};
            cand[2] = 8'h80 | {2'd0, cp[5:0]};
            ncand   = 3'd3;
          end
        end else if (hexd[4] && !end_of_text) begin
          // collect another digit
          st_dec.held[8*k +: 8] = in_byte;
          st_dec.hex_acc        = {st.hex_acc[7:0], hexd[3:0]};
          st_dec.phase          = jsu_pkg::jsu_phase_t'(st.phase + 3'd1);
        end else begin
          // malformed: replay 'u' and the held digits, then handle the byte itself as an ordinary byte
          st_dec.phase   = jsu_pkg::PH_NORMAL;
          st_dec.hex_acc = '0;
          st_dec.held    = '0;
          cand[0]        = jsu_pkg::CH_U;
          cand[1]        = st.held[7:0];
          cand[2]        = st.held[15:8];
          cand[3]        = st.held[23:16];
          ncand          = 3'd1 + {1'b0, k};
          plain_en       = 1'b1;
        end
      end
      default: begin
        st_dec.phase = jsu_pkg::PH_NORMAL;
        plain_en     = 1'b1;
      end
    endcase

    // ordinary byte handling
    if (plain_en) begin
      if (in_byte == jsu_pkg::CH_BSLASH && !end_of_text) begin
        st_dec.phase = jsu_pkg::PH_ESCAPE;
      end else begin
        cand[ncand] = in_byte;
        ncand       = ncand + 3'd1;
      end
    end

    // end of string: back to the reset state
    if (end_of_text) begin
      st_dec.phase   = jsu_pkg::PH_NORMAL;
      st_dec.hex_acc = '0;
      st_dec.held    = '0;
    end
  end

  // capacity limit: emits succeed while written + 1 < capacity
  assign cap_eff = (capacity > jsu_pkg::MAX_CAPACITY) ? jsu_pkg::MAX_CAPACITY : capacity;
  assign used    = {1'b0, st.written} + 13'd1;
  assign room    = (cap_eff > used) ? (cap_eff - used) : '0;
  assign nemit   = (room < {10'd0, ncand}) ? room[2:0] : ncand;

  // burst and length bookkeeping
  always_comb begin
    burst.data      = cand;
    burst.ndata     = nemit;
    burst.term      = end_of_text;
    burst.base      = st.written;
    st_next         = st_dec;
    st_next.written = end_of_text ? '0 : (st.written + {9'd0, nemit});
  end

  assign has_result = (nemit != 3'd0) || end_of_text;

endmodule

`default_nettype wire

// File: design/jsu_burst_queue.sv
// ---------------------------------------------------------------------------
// jsu_burst_queue: two-entry burst queue and result serialiser
// Holds decoded bursts and hands out their results one transfer at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jsu_burst_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  var jsu_pkg::jsu_burst_t  push_burst,
  output logic                     full,
  jsu_out_if.source                dst
);

  jsu_pkg::jsu_burst_t entries [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic [2:0]          idx;
  jsu_pkg::jsu_burst_t head;
  logic [2:0]          total;
  logic                last;
  logic                xfer;
  logic                pop;

  assign head  = entries[rd_ptr];
  assign total = head.ndata + {2'd0, head.term};
  assign last  = (idx + 3'd1) == total;
  assign xfer  = dst.valid && dst.ready;
  assign pop   = xfer && last;
  assign full  = (count == 2'd2);

  // result fields from the head burst
  always_comb begin
    dst.valid    = (count != 2'd0);
    dst.run_last = last;
    if (idx < head.ndata) begin
      dst.out_byte      = head.data[idx];
      dst.is_terminator = 1'b0;
      dst.text_length   = head.base + {9'd0, idx} + 12'd1;
    end else begin
      dst.out_byte      = 8'd0;
      dst.is_terminator = 1'b1;
      dst.text_length   = head.base + {9'd0, head.ndata};
    end
  end

  // burst storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_burst;
    end
  end

  // pointers, fill count and position within the head burst
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      idx    <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
      if (xfer) begin
        idx <= last ? 3'd0 : (idx + 3'd1);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/json_string_unescape_utf8.sv
// ---------------------------------------------------------------------------
// json_string_unescape_utf8: streaming JSON string unescaper
// Takes string content bytes and writes decoded bytes with UTF-8 for \u.
// ---------------------------------------------------------------------------
// Usage:
//   text    : one content byte per transfer; end_of_text marks the last one.
//   decoded : decoded bytes, then a terminator carrying the length after
//             the last byte; run_last flags the final result of each byte.
//   cfg_we / cfg_data : destination size, at most size-1 bytes are written.
//   Each input byte is decoded in the cycle it is transferred and its results
//   (none to six) enter a two-entry burst queue, whose registered entries
//   offer them on the decoded channel.
//   One input byte per cycle is taken while bytes give at most one result
//   each and the receiver is ready; a byte giving n results occupies the
//   output for n transfers; two queue entries set how far input runs ahead.
//   When the receiver stalls, input keeps flowing until both queue entries
//   hold results, then text.ready drops; nothing is lost.
//   Reset (rst, synchronous) empties the queue, clears the escape state and
//   length, and sets the destination size to 64.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8 (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [jsu_pkg::CAP_W-1:0] cfg_data,
  jsu_in_if.sink                         text,
  jsu_out_if.source                      decoded
);

  jsu_pkg::jsu_state_t        st;
  jsu_pkg::jsu_state_t        st_next;
  jsu_pkg::jsu_burst_t        burst;
  logic [jsu_pkg::CAP_W-1:0]  capacity;
  logic                       has_result;
  logic                       full;
  logic                       accept;

  assign text.ready = ~full;
  assign accept     = text.valid && text.ready;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= jsu_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  // decoder state, advanced on every input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  jsu_decode u_decode (
    .st          (st),
    .capacity    (capacity),
    .in_byte     (text.in_byte),
    .end_of_text (text.end_of_text),
    .st_next     (st_next),
    .burst       (burst),
    .has_result  (has_result)
  );

  jsu_burst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept && has_result),
    .push_burst (burst),
    .full       (full),
    .dst        (decoded)
  );

endmodule

`default_nettype wire
